// File: hdl/nearest_point_table_defines.svh
// Assertion macros used by the checker of this block.
`ifndef NEAREST_POINT_TABLE_DEFINES_SVH
`define NEAREST_POINT_TABLE_DEFINES_SVH

// Same-cycle implication.
`define NPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/npt_pkg.sv
package npt_pkg;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_NEAREST = 2'd2,
      KIND_NOP     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic append;
      logic remove;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } sample_tag_type;

endpackage

// File: hdl/npt_req_if.sv
interface npt_req_if #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 8
) ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic signed [COORD_BITS-1:0] in_x;
   logic signed [COORD_BITS-1:0] in_y;
   logic [INDEX_BITS-1:0]        in_index;

   modport source (output valid, kind, in_x, in_y, in_index, input ready);
   modport sink (input valid, kind, in_x, in_y, in_index, output ready);
endinterface

// File: hdl/npt_rsp_if.sv
interface npt_rsp_if #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 8,
   parameter int COUNT_BITS = 9
) ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [INDEX_BITS-1:0]        found_index;
   logic signed [COORD_BITS-1:0] found_x;
   logic signed [COORD_BITS-1:0] found_y;
   logic [2*COORD_BITS:0]        best_distance;
   logic [COUNT_BITS-1:0]        point_count;

   modport source (output valid, status, found_index, found_x, found_y, best_distance,
                   point_count, input ready);
   modport sink (input valid, status, found_index, found_x, found_y, best_distance,
                 point_count, output ready);
endinterface

// File: hdl/npt_cell.sv
module npt_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 8,
   parameter int COUNT_BITS = 9
) (
   input  logic                         clock,
   input  npt_pkg::cell_ctrl_type       ctrl,
   input  logic [COUNT_BITS-1:0]        count,
   input  logic [INDEX_BITS-1:0]        remove_index,
   input  logic signed [COORD_BITS-1:0] new_x,
   input  logic signed [COORD_BITS-1:0] new_y,
   input  logic signed [COORD_BITS-1:0] next_x,
   input  logic signed [COORD_BITS-1:0] next_y,
   input  logic signed [COORD_BITS-1:0] head_x,
   input  logic signed [COORD_BITS-1:0] head_y,
   output logic signed [COORD_BITS-1:0] cell_x,
   output logic signed [COORD_BITS-1:0] cell_y
);

   localparam logic [COUNT_BITS-1:0] MY_POS   = COUNT_BITS'(CELL_INDEX);
   localparam logic [COUNT_BITS-1:0] NEXT_POS = COUNT_BITS'(CELL_INDEX + 1);

   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;
   logic                         at_tail;
   logic                         in_shift;

   assign at_tail  = (NEXT_POS == count);
   assign in_shift = (MY_POS >= COUNT_BITS'(remove_index)) && (NEXT_POS < count);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ctrl.append && (MY_POS == count)) begin
         x_in = new_x;
         y_in = new_y;
      end else if (ctrl.remove && in_shift) begin
         x_in = next_x;
         y_in = next_y;
      end else if (ctrl.rotate) begin
         // close the ring at the last live entry
         x_in = at_tail ? head_x : next_x;
         y_in = at_tail ? head_y : next_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign cell_x = x_ff;
   assign cell_y = y_ff;

endmodule

// File: hdl/npt_dist.sv
module npt_dist #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  npt_pkg::sample_tag_type      tag,
   input  logic [INDEX_BITS-1:0]        sample_index,
   input  logic signed [COORD_BITS-1:0] sample_x,
   input  logic signed [COORD_BITS-1:0] sample_y,
   input  logic signed [COORD_BITS-1:0] query_x,
   input  logic signed [COORD_BITS-1:0] query_y,
   output logic                         done,
   output logic [INDEX_BITS-1:0]        best_index,
   output logic signed [COORD_BITS-1:0] best_x,
   output logic signed [COORD_BITS-1:0] best_y,
   output logic [2*COORD_BITS:0]        best_distance
);

   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = 2 * COORD_BITS + 1;

   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic signed [COORD_BITS:0]   abs_x, abs_y;

   npt_pkg::sample_tag_type      a_tag_ff, b_tag_ff;
   logic [INDEX_BITS-1:0]        a_index_ff, b_index_ff;
   logic signed [COORD_BITS-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic [COORD_BITS-1:0]        a_dx_ff, a_dy_ff;
   logic [SQ_BITS-1:0]           sq_x, sq_y;
   logic [SQ_BITS-1:0]           b_sqx_ff, b_sqy_ff;
   logic [DIST_BITS-1:0]         sum;
   logic                         take;

   logic                         done_ff;
   logic [INDEX_BITS-1:0]        best_index_ff;
   logic signed [COORD_BITS-1:0] best_x_ff, best_y_ff;
   logic [DIST_BITS-1:0]         best_dist_ff;

   assign diff_x = {sample_x[COORD_BITS-1], sample_x} - {query_x[COORD_BITS-1], query_x};
   assign diff_y = {sample_y[COORD_BITS-1], sample_y} - {query_y[COORD_BITS-1], query_y};
   assign abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
   assign abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;

   assign sq_x = a_dx_ff * a_dx_ff;
   assign sq_y = a_dy_ff * a_dy_ff;

   assign sum  = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   assign take = b_tag_ff.valid && (b_tag_ff.first || (sum < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         a_tag_ff <= tag;
         b_tag_ff <= a_tag_ff;
         done_ff  <= b_tag_ff.valid && b_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      a_index_ff <= sample_index;
      a_x_ff     <= sample_x;
      a_y_ff     <= sample_y;
      a_dx_ff    <= abs_x[COORD_BITS-1:0];
      a_dy_ff    <= abs_y[COORD_BITS-1:0];
      b_index_ff <= a_index_ff;
      b_x_ff     <= a_x_ff;
      b_y_ff     <= a_y_ff;
      b_sqx_ff   <= sq_x;
      b_sqy_ff   <= sq_y;
      if (take) begin
         best_index_ff <= b_index_ff;
         best_x_ff     <= b_x_ff;
         best_y_ff     <= b_y_ff;
         best_dist_ff  <= sum;
      end
   end

   assign done          = done_ff;
   assign best_index    = best_index_ff;
   assign best_x        = best_x_ff;
   assign best_y        = best_y_ff;
   assign best_distance = best_dist_ff;

endmodule

// File: hdl/nearest_point_table.sv
// Nearest point table: an ordered table of up to MAX_POINTS 2D points.
// req carries one item per transfer: add (append a point), remove (delete
// the entry at in_index and close the gap) or nearest (find the entry with
// the least squared distance to in_x/in_y, lowest index on a tie). Every
// item gives exactly one transfer on rsp with a status and the entry count.
// Add, remove and the unused kind update the table and stage the result,
// then move it to the output register once rsp is free. For nearest the
// live entries rotate round the chain of cells, one per cycle, past a
// single three-stage distance and compare unit, and the best entry is then
// staged and moved to the output register. One item is in the block at a
// time; req is ready again once the result is in the output register, so
// the next item overlaps a result still waiting.
// When rsp is stalled the result holds in the output register and the
// following result waits in the staging register.
// Reset empties the table and clears rsp valid; the entries themselves
// are not cleared.
module nearest_point_table #(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   npt_req_if.sink  req,
   npt_rsp_if.source rsp
);

   localparam int INDEX_BITS = $clog2(MAX_POINTS);
   localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);
   localparam int DIST_BITS  = 2 * COORD_BITS + 1;
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_POINTS);

   npt_pkg::state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [INDEX_BITS-1:0]        issue_ff, issue_in;
   logic signed [COORD_BITS-1:0] query_x_ff, query_x_in, query_y_ff, query_y_in;

   npt_pkg::status_type          res_status_ff, res_status_in;
   logic [INDEX_BITS-1:0]        res_index_ff, res_index_in;
   logic signed [COORD_BITS-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [DIST_BITS-1:0]         res_dist_ff, res_dist_in;
   logic [COUNT_BITS-1:0]        res_count_ff, res_count_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   npt_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [DIST_BITS-1:0]         rsp_dist_ff, rsp_dist_in;
   logic [COUNT_BITS-1:0]        rsp_count_ff, rsp_count_in;

   npt_pkg::cell_ctrl_type       cell_ctrl;
   npt_pkg::sample_tag_type      sample_tag;
   logic                         issue_last;

   logic signed [COORD_BITS-1:0] cell_x [MAX_POINTS];
   logic signed [COORD_BITS-1:0] cell_y [MAX_POINTS];

   logic                         dist_done;
   logic [INDEX_BITS-1:0]        dist_index;
   logic signed [COORD_BITS-1:0] dist_x, dist_y;
   logic [DIST_BITS-1:0]         dist_value;

   assign req.ready  = (state_ff == npt_pkg::ST_IDLE);
   assign issue_last = ((COUNT_BITS'(issue_ff) + COUNT_BITS'(1)) == count_ff);

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic signed [COORD_BITS-1:0] next_x, next_y;
      if (i < MAX_POINTS - 1) begin : g_link
         assign next_x = cell_x[i+1];
         assign next_y = cell_y[i+1];
      end else begin : g_wrap
         assign next_x = cell_x[0];
         assign next_y = cell_y[0];
      end
      npt_cell #(
         .CELL_INDEX (i),
         .COORD_BITS (COORD_BITS),
         .INDEX_BITS (INDEX_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .count        (count_ff),
         .remove_index (req.in_index),
         .new_x        (req.in_x),
         .new_y        (req.in_y),
         .next_x       (next_x),
         .next_y       (next_y),
         .head_x       (cell_x[0]),
         .head_y       (cell_y[0]),
         .cell_x       (cell_x[i]),
         .cell_y       (cell_y[i])
      );
   end

   assign sample_tag.valid = (state_ff == npt_pkg::ST_ISSUE);
   assign sample_tag.first = (issue_ff == '0);
   assign sample_tag.last  = issue_last;

   npt_dist #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .tag           (sample_tag),
      .sample_index  (issue_ff),
      .sample_x      (cell_x[0]),
      .sample_y      (cell_y[0]),
      .query_x       (query_x_ff),
      .query_y       (query_y_ff),
      .done          (dist_done),
      .best_index    (dist_index),
      .best_x        (dist_x),
      .best_y        (dist_y),
      .best_distance (dist_value)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      query_x_in    = query_x_ff;
      query_y_in    = query_y_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_dist_in   = res_dist_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_count_in  = rsp_count_ff;
      cell_ctrl     = '0;

      case (state_ff)
         npt_pkg::ST_IDLE: begin
            if (req.valid) begin
               query_x_in    = req.in_x;
               query_y_in    = req.in_y;
               issue_in      = '0;
               res_status_in = npt_pkg::STATUS_OK;
               res_index_in  = '0;
               res_x_in      = '0;
               res_y_in      = '0;
               res_dist_in   = '0;
               state_in      = npt_pkg::ST_DELIVER;
               case (npt_pkg::kind_type'(req.kind))
                  npt_pkg::KIND_ADD: begin
                     if (count_ff == FULL_COUNT) begin
                        res_status_in = npt_pkg::STATUS_FULL;
                     end else begin
                        cell_ctrl.append = 1'b1;
                        count_in         = count_ff + COUNT_BITS'(1);
                     end
                  end
                  npt_pkg::KIND_REMOVE: begin
                     if ((count_ff == '0) || (COUNT_BITS'(req.in_index) >= count_ff)) begin
                        res_status_in = npt_pkg::STATUS_BAD_INDEX;
                     end else begin
                        cell_ctrl.remove = 1'b1;
                        count_in         = count_ff - COUNT_BITS'(1);
                     end
                  end
                  npt_pkg::KIND_NEAREST: begin
                     if (count_ff == '0) begin
                        res_status_in = npt_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = npt_pkg::ST_ISSUE;
                     end
                  end
                  default: begin
                  end
               endcase
               res_count_in = count_in;
            end
         end
         npt_pkg::ST_ISSUE: begin
            cell_ctrl.rotate = 1'b1;
            issue_in         = issue_ff + INDEX_BITS'(1);
            if (issue_last) begin
               state_in = npt_pkg::ST_WAIT;
            end
         end
         npt_pkg::ST_WAIT: begin
            if (dist_done) begin
               res_index_in = dist_index;
               res_x_in     = dist_x;
               res_y_in     = dist_y;
               res_dist_in  = dist_value;
               state_in     = npt_pkg::ST_DELIVER;
            end
         end
         npt_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_dist_in   = res_dist_ff;
               rsp_count_in  = res_count_ff;
               state_in      = npt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npt_pkg::ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_x_ff    <= query_x_in;
      query_y_ff    <= query_y_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_dist_ff   <= res_dist_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.found_index   = rsp_index_ff;
   assign rsp.found_x       = rsp_x_ff;
   assign rsp.found_y       = rsp_y_ff;
   assign rsp.best_distance = rsp_dist_ff;
   assign rsp.point_count   = rsp_count_ff;

endmodule

// File: hdl/npt_checker.sv
`include "nearest_point_table_defines.svh"

module npt_checker #(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic [$clog2(MAX_POINTS)-1:0] rsp_found_index,
   input logic [2*COORD_BITS:0]         rsp_best_distance,
   input logic [$clog2(MAX_POINTS+1)-1:0] rsp_point_count
);

   localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_POINTS);

   `NPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_point_count), "stalled result changed")
   `NPT_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_point_count <= FULL_COUNT, "entry count beyond table size")
   `NPT_ASSERT_IMP(a_full_count, clock, reset, rsp_valid && (rsp_status == npt_pkg::STATUS_FULL), rsp_point_count == FULL_COUNT, "full status with free entries")
   `NPT_ASSERT_IMP(a_empty_search, clock, reset, rsp_valid && (rsp_status == npt_pkg::STATUS_EMPTY), (rsp_point_count == '0) && (rsp_best_distance == '0), "empty search with entries or distance")
   `NPT_ASSERT_IMP(a_found_live, clock, reset, rsp_valid && (rsp_best_distance != '0), COUNT_BITS'(rsp_found_index) < rsp_point_count, "nearest entry beyond entry count")

endmodule

bind nearest_point_table npt_checker #(
   .MAX_POINTS (MAX_POINTS),
   .COORD_BITS (COORD_BITS)
) u_npt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_found_index   (rsp.found_index),
   .rsp_best_distance (rsp.best_distance),
   .rsp_point_count   (rsp.point_count)
);
